FILE: rtl/evhp_pkg.sv
// Shared types and constants for the Ethernet VLAN header parser.
// No dependencies; every other file of the block imports this package.
`timescale 1ns / 1ps

package evhp_pkg;

    // Default limit on nested VLAN tags.
    localparam int DEF_MAX_VLAN_TAGS = 2;

    // Header geometry in bytes.
    localparam int BASE_LEN = 14;
    localparam int TAG_LEN  = 4;

    // Byte positions inside the untagged header.
    localparam int SRC_MAC_START = 6;
    localparam int TYPE_HI_POS   = 12;
    localparam int TYPE_LO_POS   = 13;

    // Configuration register map.
    localparam int CFG_IDX_W = 2;

    typedef enum logic [CFG_IDX_W-1:0] {
        CFG_CVLAN_TPID = 2'd0,
        CFG_SVLAN_TPID = 2'd1
    } cfg_index_t;

    localparam logic [15:0] CVLAN_TPID_RESET = 16'h8100;
    localparam logic [15:0] SVLAN_TPID_RESET = 16'h88A8;

    // Kind of record on the output.
    typedef enum logic [1:0] {
        REC_TAG    = 2'd0,
        REC_HEADER = 2'd1,
        REC_ERROR  = 2'd2
    } record_kind_t;

    // Error codes carried in an error record.
    typedef enum logic [1:0] {
        ERR_NONE  = 2'd0,
        ERR_SHORT = 2'd1,
        ERR_TRUNC = 2'd2,
        ERR_TAGS  = 2'd3
    } error_code_t;

    // Parser phase within a frame.
    typedef enum logic {
        PH_PARSE = 1'b0,
        PH_SKIP  = 1'b1
    } phase_t;

    // One output record as it travels between the parser and the output buffer.
    typedef struct packed {
        record_kind_t record_kind;
        logic [47:0]  dst_mac;
        logic [47:0]  src_mac;
        logic [15:0]  outer_type;
        logic [15:0]  payload_type;
        logic [4:0]   header_length;
        logic [1:0]   tag_count;
        error_code_t  error_code;
        logic [15:0]  tag_tpid;
        logic [2:0]   tag_pcp;
        logic         tag_dei;
        logic [11:0]  tag_vid;
    } record_t;

endpackage

FILE: rtl/evhp_if.sv
// Channel interfaces of the parser: frame bytes in, records out, register writes.
// Depends on evhp_pkg for the register index width.
`timescale 1ns / 1ps

// Frame byte stream.
interface evhp_frame_if;
    logic       valid;
    logic       ready;
    logic [7:0] data_byte;
    logic       frame_last;

    modport source (output valid, output data_byte, output frame_last, input ready);
    modport sink   (input valid, input data_byte, input frame_last, output ready);
endinterface

// Parsed record stream.
interface evhp_record_if;
    logic        valid;
    logic        ready;
    logic [1:0]  record_kind;
    logic [47:0] dst_mac;
    logic [47:0] src_mac;
    logic [15:0] outer_type;
    logic [15:0] payload_type;
    logic [4:0]  header_length;
    logic [1:0]  tag_count;
    logic [1:0]  error_code;
    logic [15:0] tag_tpid;
    logic [2:0]  tag_pcp;
    logic        tag_dei;
    logic [11:0] tag_vid;

    modport source (
        output valid, output record_kind, output dst_mac, output src_mac,
        output outer_type, output payload_type, output header_length,
        output tag_count, output error_code, output tag_tpid, output tag_pcp,
        output tag_dei, output tag_vid, input ready
    );
    modport sink (
        input valid, input record_kind, input dst_mac, input src_mac,
        input outer_type, input payload_type, input header_length,
        input tag_count, input error_code, input tag_tpid, input tag_pcp,
        input tag_dei, input tag_vid, output ready
    );
endinterface

// Configuration register write channel.
interface evhp_cfg_if
    import evhp_pkg::*;
;
    logic                 valid;
    logic                 ready;
    logic [CFG_IDX_W-1:0] index;
    logic [15:0]          data;

    modport source (output valid, output index, output data, input ready);
    modport sink   (input valid, input index, input data, output ready);
endinterface

FILE: rtl/evhp_parse.sv
// Per-byte header parser: frame state registers and the record decision logic.
// Depends on evhp_pkg for record types, codes and header geometry.
`timescale 1ns / 1ps

module evhp_parse
    import evhp_pkg::*;
#(
    parameter int MAX_VLAN_TAGS = DEF_MAX_VLAN_TAGS
) (
    input  logic        clk,
    input  logic        rst_n,
    input  logic        step,
    input  logic [7:0]  data_byte,
    input  logic        frame_last,
    input  logic [15:0] cvlan_tpid,
    input  logic [15:0] svlan_tpid,
    output record_t     rec,
    output logic        rec_valid
);

    // The furthest a frame can advance is the TPID that overflows the tag limit.
    localparam int MAX_POS = TYPE_LO_POS + TAG_LEN * MAX_VLAN_TAGS + 1;
    localparam int POS_W   = $clog2(MAX_POS + 1);
    localparam int TAG_W   = $clog2(MAX_VLAN_TAGS + 1);
    localparam int LEN_W   = $clog2(BASE_LEN + TAG_LEN * MAX_VLAN_TAGS + 1);

    logic [POS_W-1:0] pos_reg, pos_next;
    logic [47:0]      dst_reg, dst_next;
    logic [47:0]      src_reg, src_next;
    logic [15:0]      outer_reg, outer_next;
    logic [15:0]      cur_type_reg, cur_type_next;
    logic [15:0]      tci_reg, tci_next;
    logic [TAG_W-1:0] tags_reg, tags_next;
    phase_t           phase_reg, phase_next;

    logic [15:0]      type_full;
    logic             is_tag;
    logic             type_done;
    logic [TAG_W-1:0] tags_inc;
    logic [1:0]       tag_idx;
    logic [15:0]      outer_now;

    // Header length for a given tag count, wrapped to the field width.
    function automatic logic [4:0] len_of(input logic [TAG_W-1:0] t);
        logic [LEN_W-1:0] full;
        full = LEN_W'(BASE_LEN) + LEN_W'(t) * LEN_W'(TAG_LEN);
        return 5'(full);
    endfunction

    assign type_full = {cur_type_reg[15:8], data_byte};
    assign is_tag    = (type_full == cvlan_tpid) || (type_full == svlan_tpid);
    assign tags_inc  = tags_reg + 1'b1;
    assign tag_idx   = 2'(pos_reg - POS_W'(BASE_LEN));
    assign outer_now = (pos_reg == POS_W'(TYPE_LO_POS)) ? type_full : outer_reg;

    // Next frame state and the record, if any, caused by this byte.
    always_comb
    begin
        pos_next      = pos_reg;
        dst_next      = dst_reg;
        src_next      = src_reg;
        outer_next    = outer_reg;
        cur_type_next = cur_type_reg;
        tci_next      = tci_reg;
        tags_next     = tags_reg;
        phase_next    = phase_reg;
        rec           = '0;
        rec_valid     = 1'b0;
        type_done     = 1'b0;

        unique case (phase_reg)
            PH_SKIP:
            begin
                if (frame_last)
                begin
                    pos_next   = '0;
                    tags_next  = '0;
                    phase_next = PH_PARSE;
                end
            end
            PH_PARSE:
            begin
                pos_next = pos_reg + 1'b1;

                // Collect the byte into the field it belongs to.
                priority if (pos_reg < POS_W'(SRC_MAC_START))
                begin
                    dst_next = {dst_reg[39:0], data_byte};
                end
                else if (pos_reg < POS_W'(TYPE_HI_POS))
                begin
                    src_next = {src_reg[39:0], data_byte};
                end
                else if (pos_reg == POS_W'(TYPE_HI_POS))
                begin
                    cur_type_next = {data_byte, 8'h00};
                end
                else if (pos_reg == POS_W'(TYPE_LO_POS))
                begin
                    outer_next    = type_full;
                    cur_type_next = type_full;
                    type_done     = 1'b1;
                end
                else
                begin
                    unique case (tag_idx)
                        2'd0: tci_next = {data_byte, 8'h00};
                        2'd1: tci_next = {tci_reg[15:8], data_byte};
                        2'd2:
                        begin
                            // The tag is complete once its inner type starts.
                            if (!frame_last)
                            begin
                                tags_next         = tags_inc;
                                rec.record_kind   = REC_TAG;
                                rec.dst_mac       = dst_reg;
                                rec.src_mac       = src_reg;
                                rec.outer_type    = outer_reg;
                                rec.header_length = len_of(tags_inc);
                                rec.tag_count     = 2'(tags_inc);
                                rec.tag_tpid      = cur_type_reg;
                                rec.tag_pcp       = tci_reg[15:13];
                                rec.tag_dei       = tci_reg[12];
                                rec.tag_vid       = tci_reg[11:0];
                                rec_valid         = 1'b1;
                            end
                            cur_type_next = {data_byte, 8'h00};
                        end
                        default:
                        begin
                            cur_type_next = type_full;
                            type_done     = 1'b1;
                        end
                    endcase
                end

                // A complete EtherType ends the header, overflows the tag limit,
                // or opens another tag.
                if (type_done)
                begin
                    if (!is_tag)
                    begin
                        rec.record_kind   = REC_HEADER;
                        rec.dst_mac       = dst_reg;
                        rec.src_mac       = src_reg;
                        rec.outer_type    = outer_now;
                        rec.payload_type  = type_full;
                        rec.header_length = len_of(tags_reg);
                        rec.tag_count     = 2'(tags_reg);
                        rec_valid         = 1'b1;
                        phase_next        = PH_SKIP;
                    end
                    else if (tags_reg >= TAG_W'(MAX_VLAN_TAGS))
                    begin
                        rec.record_kind   = REC_ERROR;
                        rec.error_code    = ERR_TAGS;
                        rec.header_length = len_of(tags_reg);
                        rec.tag_count     = 2'(tags_reg);
                        rec_valid         = 1'b1;
                        phase_next        = PH_SKIP;
                    end
                end

                // The frame ends here: report it if nothing else was said.
                if (frame_last)
                begin
                    if (!rec_valid)
                    begin
                        rec               = '0;
                        rec.record_kind   = REC_ERROR;
                        rec.error_code    = (pos_reg < POS_W'(TYPE_LO_POS)) ? ERR_SHORT
                                                                            : ERR_TRUNC;
                        rec.header_length = len_of(tags_reg);
                        rec.tag_count     = 2'(tags_reg);
                        rec_valid         = 1'b1;
                    end
                    pos_next   = '0;
                    tags_next  = '0;
                    phase_next = PH_PARSE;
                end
            end
            default:
            begin
                phase_next = PH_PARSE;
            end
        endcase
    end

    // Frame control state.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            pos_reg   <= '0;
            tags_reg  <= '0;
            phase_reg <= PH_PARSE;
        end
        else if (step)
        begin
            pos_reg   <= pos_next;
            tags_reg  <= tags_next;
            phase_reg <= phase_next;
        end
    end

    // Header fields; each is fully rewritten before it is used.
    always_ff @(posedge clk)
    begin
        if (step)
        begin
            dst_reg      <= dst_next;
            src_reg      <= src_next;
            outer_reg    <= outer_next;
            cur_type_reg <= cur_type_next;
            tci_reg      <= tci_next;
        end
    end

    // Bytes after a header or an error never produce a record.
    a_skip_silent: assert property (@(posedge clk) disable iff (!rst_n)
        (phase_reg == PH_SKIP) |-> !rec_valid)
        else $error("record produced while skipping to frame end");

    // Only the tag overflow error can appear before the last byte of a frame.
    a_early_error: assert property (@(posedge clk) disable iff (!rst_n)
        (rec_valid && rec.record_kind == REC_ERROR && !frame_last)
            |-> rec.error_code == ERR_TAGS)
        else $error("early error record with wrong code");

    // The byte position never runs past the deepest legal header.
    a_pos_bound: assert property (@(posedge clk) disable iff (!rst_n)
        pos_reg <= POS_W'(MAX_POS))
        else $error("byte position out of range");

    // The tag count never exceeds the configured limit.
    a_tags_bound: assert property (@(posedge clk) disable iff (!rst_n)
        step |=> tags_reg <= TAG_W'(MAX_VLAN_TAGS))
        else $error("tag count above limit");

endmodule

FILE: rtl/evhp_out_buf.sv
// Two-entry output buffer: an output register plus a skid register for records.
// Depends on evhp_pkg for the record type.
`timescale 1ns / 1ps

module evhp_out_buf
    import evhp_pkg::*;
(
    input  logic    clk,
    input  logic    rst_n,
    input  logic    push,
    input  record_t push_rec,
    output logic    full,
    output logic    out_valid,
    input  logic    out_ready,
    output record_t out_rec
);

    logic    out_valid_reg, out_valid_next;
    logic    skid_valid_reg, skid_valid_next;
    record_t out_rec_reg, out_rec_next;
    record_t skid_reg, skid_next;
    logic    pop;

    assign pop       = out_valid_reg && out_ready;
    assign full      = skid_valid_reg;
    assign out_valid = out_valid_reg;
    assign out_rec   = out_rec_reg;

    // Move records from the skid register to the output register as the sink drains.
    always_comb
    begin
        out_valid_next  = out_valid_reg;
        skid_valid_next = skid_valid_reg;
        out_rec_next    = out_rec_reg;
        skid_next       = skid_reg;

        if (skid_valid_reg)
        begin
            if (pop)
            begin
                out_rec_next    = skid_reg;
                skid_valid_next = 1'b0;
            end
        end
        else if (!out_valid_reg || pop)
        begin
            out_valid_next = push;
            if (push)
            begin
                out_rec_next = push_rec;
            end
        end
        else if (push)
        begin
            skid_next       = push_rec;
            skid_valid_next = 1'b1;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            out_valid_reg  <= 1'b0;
            skid_valid_reg <= 1'b0;
        end
        else
        begin
            out_valid_reg  <= out_valid_next;
            skid_valid_reg <= skid_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        out_rec_reg <= out_rec_next;
        skid_reg    <= skid_next;
    end

    // The skid register is only used behind a full output register.
    a_skid_behind_out: assert property (@(posedge clk) disable iff (!rst_n)
        skid_valid_reg |-> out_valid_reg)
        else $error("skid entry without output entry");

    // No record is pushed while both entries are occupied.
    a_no_overflow: assert property (@(posedge clk) disable iff (!rst_n)
        push |-> !skid_valid_reg)
        else $error("push into a full output buffer");

    // A drained output register takes the waiting skid record next.
    a_skid_order: assert property (@(posedge clk) disable iff (!rst_n)
        (skid_valid_reg && pop) |=> (out_valid_reg && out_rec_reg == $past(skid_reg)))
        else $error("skid record lost or reordered");

endmodule

FILE: rtl/ethernet_vlan_header_parser_unit.sv
// A byte's record, if it has one, is on the output in the cycle after the byte is taken when the buffer is empty.
// Throughput: one frame byte per cycle; the parser state updates on every byte, and a
// two-entry output buffer lets the next byte in while one record waits for the sink.
// Input is held off only while both output entries are full.
// Reset (rst_n, asynchronous, active low) clears the frame state and output buffer and
// loads the TPID registers with 0x8100 and 0x88A8.
// Top level; depends on evhp_pkg, evhp_if, evhp_parse and evhp_out_buf.
`timescale 1ns / 1ps

module ethernet_vlan_header_parser_unit
    import evhp_pkg::*;
#(
    parameter int MAX_VLAN_TAGS = DEF_MAX_VLAN_TAGS
) (
    input  logic          clk,
    input  logic          rst_n,
    evhp_frame_if.sink    frame,
    evhp_record_if.source record,
    evhp_cfg_if.sink      cfg
);

    logic [15:0] cvlan_tpid_reg;
    logic [15:0] svlan_tpid_reg;
    logic        step;
    logic        buf_full;
    logic        rec_valid;
    record_t     rec;
    record_t     out_rec;

    // TPID registers; writes to indexes outside the map are dropped.
    assign cfg.ready = 1'b1;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cvlan_tpid_reg <= CVLAN_TPID_RESET;
            svlan_tpid_reg <= SVLAN_TPID_RESET;
        end
        else if (cfg.valid)
        begin
            if (cfg.index == CFG_CVLAN_TPID)
            begin
                cvlan_tpid_reg <= cfg.data;
            end
            else if (cfg.index == CFG_SVLAN_TPID)
            begin
                svlan_tpid_reg <= cfg.data;
            end
        end
    end

    // A byte is taken whenever the output buffer has room for its record.
    assign frame.ready = !buf_full;
    assign step        = frame.valid && !buf_full;

    evhp_parse #(
        .MAX_VLAN_TAGS (MAX_VLAN_TAGS)
    ) u_parse (
        .clk        (clk),
        .rst_n      (rst_n),
        .step       (step),
        .data_byte  (frame.data_byte),
        .frame_last (frame.frame_last),
        .cvlan_tpid (cvlan_tpid_reg),
        .svlan_tpid (svlan_tpid_reg),
        .rec        (rec),
        .rec_valid  (rec_valid)
    );

    evhp_out_buf u_out_buf (
        .clk       (clk),
        .rst_n     (rst_n),
        .push      (step && rec_valid),
        .push_rec  (rec),
        .full      (buf_full),
        .out_valid (record.valid),
        .out_ready (record.ready),
        .out_rec   (out_rec)
    );

    // Unpack the buffered record onto the output channel.
    assign record.record_kind   = out_rec.record_kind;
    assign record.dst_mac       = out_rec.dst_mac;
    assign record.src_mac       = out_rec.src_mac;
    assign record.outer_type    = out_rec.outer_type;
    assign record.payload_type  = out_rec.payload_type;
    assign record.header_length = out_rec.header_length;
    assign record.tag_count     = out_rec.tag_count;
    assign record.error_code    = out_rec.error_code;
    assign record.tag_tpid      = out_rec.tag_tpid;
    assign record.tag_pcp       = out_rec.tag_pcp;
    assign record.tag_dei       = out_rec.tag_dei;
    assign record.tag_vid       = out_rec.tag_vid;

endmodule

FILE: bench/testbench.sv
// Self-checking testbench for ethernet_vlan_header_parser_unit: drives frame bytes and
// register writes, predicts every record and compares each one as it comes out.
// Depends on evhp_pkg and the channel interfaces in evhp_if.
`timescale 1ns / 1ps

module testbench
    import evhp_pkg::*;
;

    localparam int MAX_TAGS     = DEF_MAX_VLAN_TAGS;
    localparam int IDLE_PCT     = 34;
    localparam int HOLD_LEN     = 80;
    localparam int QUIET_LIMIT  = 2000;
    localparam int REPORT_LIMIT = 10;

    // Byte offsets within one VLAN tag after the outer EtherType.
    localparam int TCI_HI_OFS   = 0;
    localparam int TCI_LO_OFS   = 1;
    localparam int INNER_HI_OFS = 2;

    // An index outside the register map; writes to it must change nothing.
    localparam logic [CFG_IDX_W-1:0] CFG_IDX_UNUSED = 2'd3;

    logic clk;
    logic rst_n;

    evhp_frame_if  frame_ch ();
    evhp_record_if record_ch ();
    evhp_cfg_if    cfg_ch ();

    ethernet_vlan_header_parser_unit dut (
        .clk    (clk),
        .rst_n  (rst_n),
        .frame  (frame_ch),
        .record (record_ch),
        .cfg    (cfg_ch)
    );

    // Predicted records waiting for the block, oldest first.
    record_t expected_records[$];
    // Bytes of the frame being assembled for sending.
    logic [7:0] frame_buf[$];

    int unsigned mismatches;
    int unsigned parsed_bytes;
    int unsigned hold_cycles;
    int unsigned hold_requests;
    int unsigned hold_taken;
    bit          no_gaps;

    // Copy of the TPID registers and of the per-frame parse state.
    logic [15:0] cvlan_tpid_reg;
    logic [15:0] svlan_tpid_reg;
    int unsigned pos_in_frame;
    logic [47:0] dst_mac_acc;
    logic [47:0] src_mac_acc;
    logic [15:0] outer_type_acc;
    logic [15:0] ether_type_acc;
    logic [15:0] tci_acc;
    int unsigned tags_parsed;
    bit          skipping_frame;

    // Clock generation.
    initial
    begin
        clk = 1'b0;
        forever #2 clk = ~clk;
    end

    function automatic void clear_frame_state();
        pos_in_frame   = 0;
        dst_mac_acc    = '0;
        src_mac_acc    = '0;
        outer_type_acc = '0;
        ether_type_acc = '0;
        tci_acc        = '0;
        tags_parsed    = 0;
        skipping_frame = 1'b0;
    endfunction

    function automatic bit tpid_match(input logic [15:0] ether_type);
        return ether_type == cvlan_tpid_reg || ether_type == svlan_tpid_reg;
    endfunction

    // A record with the fields that every kind shares; error records carry no addresses.
    function automatic record_t base_record(input record_kind_t kind);
        record_t r;
        r = '0;
        r.record_kind   = kind;
        r.header_length = 5'(BASE_LEN + TAG_LEN * tags_parsed);
        r.tag_count     = 2'(tags_parsed);
        if (kind != REC_ERROR)
        begin
            r.dst_mac    = dst_mac_acc;
            r.src_mac    = src_mac_acc;
            r.outer_type = outer_type_acc;
        end
        return r;
    endfunction

    // A full EtherType has arrived: it ends the header, overflows the tag stack,
    // truncates a tag at frame end, or opens another tag.
    function automatic bit ethertype_done(input bit last, output record_t r);
        r = '0;
        if (!tpid_match(ether_type_acc))
        begin
            r = base_record(REC_HEADER);
            r.payload_type = ether_type_acc;
            skipping_frame = 1'b1;
            return 1'b1;
        end
        if (tags_parsed >= MAX_TAGS)
        begin
            r = base_record(REC_ERROR);
            r.error_code = ERR_TAGS;
            skipping_frame = 1'b1;
            return 1'b1;
        end
        if (last)
        begin
            r = base_record(REC_ERROR);
            r.error_code = ERR_TRUNC;
            return 1'b1;
        end
        return 1'b0;
    endfunction

    // Advance the predicted parser by one accepted byte; returns 1 if a record results.
    function automatic bit parse_byte(input logic [7:0] value, input bit last,
                                      output record_t r);
        int unsigned pos;
        bit          got;
        pos = pos_in_frame;
        got = 1'b0;
        r   = '0;
        if (skipping_frame)
        begin
            if (last)
                clear_frame_state();
            return 1'b0;
        end
        parsed_bytes++;
        pos_in_frame = pos + 1;
        if (pos < SRC_MAC_START)
            dst_mac_acc = {dst_mac_acc[39:0], value};
        else if (pos < TYPE_HI_POS)
            src_mac_acc = {src_mac_acc[39:0], value};
        else if (pos == TYPE_HI_POS)
            ether_type_acc = {value, 8'h00};
        else if (pos == TYPE_LO_POS)
        begin
            ether_type_acc[7:0] = value;
            outer_type_acc = ether_type_acc;
            got = ethertype_done(last, r);
        end
        else
        begin
            case ((pos - BASE_LEN) % TAG_LEN)
                TCI_HI_OFS:
                    tci_acc = {value, 8'h00};
                TCI_LO_OFS:
                    tci_acc[7:0] = value;
                INNER_HI_OFS:
                begin
                    // The tag is reported once its inner EtherType starts, unless the frame ends.
                    if (!last)
                    begin
                        tags_parsed++;
                        r = base_record(REC_TAG);
                        r.tag_tpid = ether_type_acc;
                        r.tag_pcp  = tci_acc[15:13];
                        r.tag_dei  = tci_acc[12];
                        r.tag_vid  = tci_acc[11:0];
                        got = 1'b1;
                    end
                    ether_type_acc = {value, 8'h00};
                end
                default:
                begin
                    ether_type_acc[7:0] = value;
                    got = ethertype_done(last, r);
                end
            endcase
        end
        // A frame that ends without a record of its own is reported as short or truncated.
        if (last)
        begin
            if (!got)
            begin
                r = base_record(REC_ERROR);
                if (pos < TYPE_LO_POS)
                    r.error_code = ERR_SHORT;
                else
                    r.error_code = ERR_TRUNC;
                got = 1'b1;
            end
            clear_frame_state();
        end
        return got;
    endfunction

    function automatic bit field_ok(input string name, input logic [63:0] want,
                                    input logic [63:0] got);
        if (want === got)
            return 1'b1;
        if (mismatches < REPORT_LIMIT)
            $display("mismatch in %s: expected 0x%0h, got 0x%0h", name, want, got);
        mismatches++;
        return 1'b0;
    endfunction

    // Record sink: random stalls, plus a long hold-off when a test asks for one.
    always @(posedge clk)
    begin
        if (hold_requests != hold_taken)
        begin
            hold_taken      <= hold_requests;
            hold_cycles     <= HOLD_LEN;
            record_ch.ready <= 1'b0;
        end
        else if (hold_cycles > 0)
        begin
            record_ch.ready <= 1'b0;
            hold_cycles <= hold_cycles - 1;
        end
        else
            record_ch.ready <= no_gaps || ($urandom_range(99) >= IDLE_PCT);
    end

    // Compare every accepted record with the oldest prediction.
    always @(posedge clk)
    begin : record_check
        record_t want;
        if (record_ch.valid && record_ch.ready)
        begin
            if (expected_records.size() == 0)
            begin
                if (mismatches < REPORT_LIMIT)
                    $display("unexpected record: kind %0d, error %0d",
                             record_ch.record_kind, record_ch.error_code);
                mismatches++;
            end
            else
            begin
                want = expected_records.pop_front();
                void'(field_ok("record_kind", 64'(want.record_kind),
                               64'(record_ch.record_kind)));
                void'(field_ok("dst_mac", 64'(want.dst_mac),
                               64'(record_ch.dst_mac)));
                void'(field_ok("src_mac", 64'(want.src_mac),
                               64'(record_ch.src_mac)));
                void'(field_ok("outer_type", 64'(want.outer_type),
                               64'(record_ch.outer_type)));
                void'(field_ok("payload_type", 64'(want.payload_type),
                               64'(record_ch.payload_type)));
                void'(field_ok("header_length", 64'(want.header_length),
                               64'(record_ch.header_length)));
                void'(field_ok("tag_count", 64'(want.tag_count),
                               64'(record_ch.tag_count)));
                void'(field_ok("error_code", 64'(want.error_code),
                               64'(record_ch.error_code)));
                void'(field_ok("tag_tpid", 64'(want.tag_tpid),
                               64'(record_ch.tag_tpid)));
                void'(field_ok("tag_pcp", 64'(want.tag_pcp),
                               64'(record_ch.tag_pcp)));
                void'(field_ok("tag_dei", 64'(want.tag_dei),
                               64'(record_ch.tag_dei)));
                void'(field_ok("tag_vid", 64'(want.tag_vid),
                               64'(record_ch.tag_vid)));
            end
        end
    end

    // Watchdog: ends the run when no channel has moved an item for too long.
    initial
    begin : watchdog
        int unsigned quiet;
        quiet = 0;
        while (quiet < QUIET_LIMIT)
        begin
            @(posedge clk);
            if ((frame_ch.valid && frame_ch.ready) || (record_ch.valid && record_ch.ready)
                || (cfg_ch.valid && cfg_ch.ready))
                quiet = 0;
            else
                quiet++;
        end
        $display("testbench: done, errors");
        $finish;
    end

    // Send one byte, idling at random first, and predict its record once accepted.
    task automatic send_byte(input logic [7:0] value, input bit last);
        record_t rec;
        while (!no_gaps && $urandom_range(99) < IDLE_PCT)
        begin
            frame_ch.valid <= 1'b0;
            @(posedge clk);
        end
        frame_ch.valid      <= 1'b1;
        frame_ch.data_byte  <= value;
        frame_ch.frame_last <= last;
        @(posedge clk);
        while (!frame_ch.ready)
            @(posedge clk);
        if (parse_byte(value, last, rec))
            expected_records.push_back(rec);
    endtask

    task automatic send_frame();
        foreach (frame_buf[i])
            send_byte(frame_buf[i], i == frame_buf.size() - 1);
        frame_buf.delete();
    endtask

    task automatic put_word(input logic [15:0] word);
        frame_buf.push_back(word[15:8]);
        frame_buf.push_back(word[7:0]);
    endtask

    task automatic put_addresses(input logic [47:0] dst, input logic [47:0] src);
        for (int i = 5; i >= 0; i--)
            frame_buf.push_back(dst[8*i +: 8]);
        for (int i = 5; i >= 0; i--)
            frame_buf.push_back(src[8*i +: 8]);
    endtask

    // Stop offering bytes and wait until every predicted record has come out.
    task automatic wait_drained();
        frame_ch.valid <= 1'b0;
        @(posedge clk);
        while (expected_records.size() != 0)
            @(posedge clk);
        repeat (4) @(posedge clk);
    endtask

    // One register write; valid is dropped again before the task returns.
    task automatic write_reg(input logic [CFG_IDX_W-1:0] index, input logic [15:0] value);
        cfg_ch.valid <= 1'b1;
        cfg_ch.index <= index;
        cfg_ch.data  <= value;
        @(posedge clk);
        while (!cfg_ch.ready)
            @(posedge clk);
        case (index)
            CFG_CVLAN_TPID: cvlan_tpid_reg = value;
            CFG_SVLAN_TPID: svlan_tpid_reg = value;
            default: ;
        endcase
        cfg_ch.valid <= 1'b0;
        @(posedge clk);
    endtask

    // Mostly well-formed frames with random tags, some cut short, some pure noise.
    task automatic send_random_frame();
        int unsigned shape;
        int unsigned cut;
        shape = $urandom_range(99);
        if (shape < 12)
        begin
            repeat ($urandom_range(24, 1))
                frame_buf.push_back(8'($urandom));
        end
        else
        begin
            put_addresses({16'($urandom), $urandom}, {16'($urandom), $urandom});
            repeat ($urandom_range(3))
            begin
                put_word($urandom_range(1) ? cvlan_tpid_reg : svlan_tpid_reg);
                put_word(16'($urandom));
            end
            put_word(16'($urandom));
            repeat ($urandom_range(6))
                frame_buf.push_back(8'($urandom));
            if (shape < 26)
            begin
                cut = $urandom_range(frame_buf.size(), 1);
                while (frame_buf.size() > cut)
                    void'(frame_buf.pop_back());
            end
        end
        send_frame();
    endtask

    task automatic run_random_traffic(input int unsigned target);
        int unsigned start;
        start = parsed_bytes;
        while (parsed_bytes - start < target)
            send_random_frame();
    endtask

    // Untagged frames with extreme addresses and EtherTypes.
    task automatic test_plain_headers();
        put_addresses(48'hFFFF_FFFF_FFFF, 48'h0);
        put_word(16'h0800);
        put_word(16'hFF00);
        send_frame();
        // Frame that ends on the last EtherType byte is still a good header.
        put_addresses(48'h0, 48'hFFFF_FFFF_FFFF);
        put_word(16'hFFFF);
        send_frame();
        put_addresses(48'h0123_4567_89AB, 48'hFEDC_BA98_7654);
        put_word(16'h0000);
        put_word(16'h5AA5);
        send_frame();
    endtask

    // Single and stacked tags, and a stack deeper than allowed.
    task automatic test_vlan_tags();
        put_addresses(48'h0200_0000_0001, 48'h0200_0000_0002);
        put_word(CVLAN_TPID_RESET);
        put_word(16'hFFFF);
        put_word(16'h86DD);
        frame_buf.push_back(8'hA5);
        send_frame();
        put_addresses(48'hA0A0_A0A0_A0A0, 48'h0505_0505_0505);
        put_word(SVLAN_TPID_RESET);
        put_word(16'h0000);
        put_word(CVLAN_TPID_RESET);
        put_word(16'h2BCD);
        put_word(16'h0800);
        put_word(16'h0000);
        send_frame();
        // Third tag overflows the stack; trailing bytes are skipped.
        put_addresses(48'h1111_2222_3333, 48'h4444_5555_6666);
        put_word(SVLAN_TPID_RESET);
        put_word(16'h6001);
        put_word(CVLAN_TPID_RESET);
        put_word(16'h8002);
        put_word(CVLAN_TPID_RESET);
        put_word(16'h0003);
        put_word(16'h0800);
        send_frame();
        // Overflow on the frame's final byte is still reported as too many tags.
        put_addresses(48'h1111_2222_3333, 48'h4444_5555_6666);
        put_word(CVLAN_TPID_RESET);
        put_word(16'h0FFF);
        put_word(SVLAN_TPID_RESET);
        put_word(16'hF000);
        put_word(CVLAN_TPID_RESET);
        send_frame();
    endtask

    // Frames that end before the outer EtherType is complete.
    task automatic test_short_frames();
        frame_buf.push_back(8'h00);
        send_frame();
        put_addresses(48'hFFFF_FFFF_FFFF, 48'hFFFF_FFFF_FFFF);
        frame_buf.push_back(8'h81);
        send_frame();
    endtask

    // Frames that end inside a tag.
    task automatic test_truncated_tags();
        put_addresses(48'h0000_0000_00FF, 48'hFF00_0000_0000);
        put_word(CVLAN_TPID_RESET);
        send_frame();
        put_addresses(48'h0000_0000_00FF, 48'hFF00_0000_0000);
        put_word(CVLAN_TPID_RESET);
        frame_buf.push_back(8'h12);
        send_frame();
        // Ends on the first inner EtherType byte, so no tag record is given.
        put_addresses(48'h0000_0000_00FF, 48'hFF00_0000_0000);
        put_word(SVLAN_TPID_RESET);
        put_word(16'h1234);
        frame_buf.push_back(8'h08);
        send_frame();
        // A tag record, then the frame ends on a second TPID.
        put_addresses(48'h0000_0000_00FF, 48'hFF00_0000_0000);
        put_word(SVLAN_TPID_RESET);
        put_word(16'hE001);
        put_word(CVLAN_TPID_RESET);
        send_frame();
    endtask

    // TPID registers: ignored index, equal values, and the extremes.
    task automatic test_tpid_registers();
        wait_drained();
        write_reg(CFG_IDX_UNUSED, 16'h0800);
        put_addresses(48'h0A0B_0C0D_0E0F, 48'h1A1B_1C1D_1E1F);
        put_word(16'h0800);
        put_word(16'h0000);
        send_frame();
        wait_drained();
        write_reg(CFG_CVLAN_TPID, 16'h0800);
        write_reg(CFG_SVLAN_TPID, 16'h0800);
        put_addresses(48'h0A0B_0C0D_0E0F, 48'h1A1B_1C1D_1E1F);
        put_word(16'h0800);
        put_word(16'h7FFF);
        put_word(CVLAN_TPID_RESET);
        put_word(16'h0000);
        send_frame();
        wait_drained();
        write_reg(CFG_CVLAN_TPID, 16'h0000);
        write_reg(CFG_SVLAN_TPID, 16'hFFFF);
        put_addresses(48'h0, 48'h0);
        put_word(16'h0000);
        put_word(16'h5555);
        put_word(16'hFFFF);
        put_word(16'hAAAA);
        put_word(16'h1234);
        send_frame();
        wait_drained();
        write_reg(CFG_CVLAN_TPID, CVLAN_TPID_RESET);
        write_reg(CFG_SVLAN_TPID, SVLAN_TPID_RESET);
    endtask

    // One-byte frames each give an error record while the sink holds off, so the
    // output buffer fills and the block must stall its input.
    task automatic test_backpressure();
        wait_drained();
        no_gaps = 1'b1;
        hold_requests++;
        repeat (30)
        begin
            frame_buf.push_back(8'($urandom));
            send_frame();
        end
        no_gaps = 1'b0;
    endtask

    task automatic test_random_default_tpids();
        run_random_traffic(110);
    endtask

    // Random TPIDs, with a gap-free stretch on both sides first.
    task automatic test_random_tpids();
        wait_drained();
        write_reg(CFG_CVLAN_TPID, 16'($urandom));
        write_reg(CFG_SVLAN_TPID, 16'($urandom));
        no_gaps = 1'b1;
        run_random_traffic(60);
        no_gaps = 1'b0;
        run_random_traffic(50);
    endtask

    task automatic test_random_extreme_tpids();
        wait_drained();
        write_reg(CFG_CVLAN_TPID, 16'hFFFF);
        write_reg(CFG_SVLAN_TPID, 16'h0000);
        run_random_traffic(110);
    endtask

    // Test sequence.
    initial
    begin
        frame_ch.valid      <= 1'b0;
        frame_ch.data_byte  <= '0;
        frame_ch.frame_last <= 1'b0;
        cfg_ch.valid        <= 1'b0;
        cfg_ch.index        <= '0;
        cfg_ch.data         <= '0;
        rst_n               <= 1'b0;
        parsed_bytes   = 0;
        no_gaps        = 1'b0;
        cvlan_tpid_reg = CVLAN_TPID_RESET;
        svlan_tpid_reg = SVLAN_TPID_RESET;
        clear_frame_state();
        repeat (2) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        test_plain_headers();
        test_vlan_tags();
        test_short_frames();
        test_truncated_tags();
        test_tpid_registers();
        test_backpressure();
        test_random_default_tpids();
        test_random_tpids();
        test_random_extreme_tpids();

        wait_drained();
        repeat (10) @(posedge clk);
        if (mismatches == 0 && expected_records.size() == 0)
            $display("testbench: done, clean");
        else
            $display("testbench: done, errors");
        $finish;
    end

endmodule
